// ----- rtl/core/pic_pkg.sv -----
`timescale 1ns / 1ps

package pic_pkg;

    localparam int CHANNELS    = 16;
    localparam int CH_W        = 4;
    localparam int CFG_W       = 16;
    localparam int READ_W      = 32;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 56;

    typedef enum logic
    {
        REG_ENABLE       = 1'b0,
        REG_CHANNEL_MASK = 1'b1
    } reg_index_t;

    typedef enum logic
    {
        OP_TICK = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef logic [CHANNELS-1:0] chan_mask_t;

endpackage

// ----- rtl/core/pulse_input_edge_counter.sv -----
`timescale 1ns / 1ps

// Sixteen-channel active-low pulse counter with SLOT_COUNT banks of COUNT_WIDTH-bit wrapping
// counters. Each transaction is either a sample tick or a counter read, and yields exactly
// one result. The accepting edge registers the item together with the addressed bank row,
// read from the counter memory (one row per bank, one read and one write port, with forwarding
// of a write to the same row in the same cycle); the edge that commits it, once the output
// register is free or being taken, writes the updated row back and registers the result.
// A new item is accepted every cycle while the result side keeps taking results. Bank rows are
// marked valid once written and read as zero before that, so no clearing pass follows reset.
// A channel counts only when it is active now and was inactive on the three previous enabled
// ticks, so nothing counts in the first three enabled ticks after reset.
module pulse_input_edge_counter #(
    parameter int SLOT_COUNT  = 2,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [pic_pkg::CFG_W-1:0]       cfg_wdata,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] pin_levels, [16] slot, [20:17] read_channel, [23:21] zero
    input  logic [pic_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] operation
    input  logic                            s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [15:0] qualified_pulses, [16] pulse_seen, [48:17] count_value, [55:49] zero
    output logic [pic_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    import pic_pkg::*;

    localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef logic [CHANNELS-1:0][COUNT_WIDTH-1:0] row_t;

    logic                   enable_reg;
    chan_mask_t             mask_reg;
    chan_mask_t             hist0_reg;
    chan_mask_t             hist1_reg;
    chan_mask_t             hist2_reg;
    logic                   seen_reg;

    logic                   s1_valid_reg;
    op_t                    op_reg;
    chan_mask_t             pins_reg;
    logic                   slot_reg;
    logic [CH_W-1:0]        rch_reg;
    row_t                   row_reg;

    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [OUT_DATA_W-1:0]  out_data_next;

    row_t                   mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]  row_valid_reg;

    logic                   accept;
    logic                   commit;
    logic                   s1_advance;
    logic [SLOT_AW-1:0]     in_addr;
    logic                   in_ok;
    logic                   in_slot;
    logic [SLOT_AW-1:0]     s1_addr;
    logic                   s1_ok;
    logic                   tick_on;
    chan_mask_t             qual;
    logic                   seen_next;
    logic                   mem_we;
    logic                   fwd;
    row_t                   row_wr;
    logic [READ_W-1:0]      count_value;

    assign s1_advance    = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign commit        = s1_valid_reg && s1_advance;

    assign in_slot = s_axis_tdata[16];
    assign in_addr = SLOT_AW'(in_slot);
    assign in_ok   = (32'(in_slot) < SLOT_COUNT);
    assign s1_addr = SLOT_AW'(slot_reg);
    assign s1_ok   = (32'(slot_reg) < SLOT_COUNT);

    always_comb
    begin
        tick_on = (op_reg == OP_TICK) && enable_reg;
        qual    = '0;
        if (tick_on)
        begin
            qual = ~pins_reg & hist0_reg & hist1_reg & hist2_reg & mask_reg;
        end
        seen_next = seen_reg || (qual != '0);
        for (int i = 0; i < CHANNELS; i++)
        begin
            row_wr[i] = row_reg[i] + {{(COUNT_WIDTH-1){1'b0}}, qual[i]};
        end
        mem_we      = commit && tick_on && s1_ok;
        fwd         = mem_we && (s1_addr == in_addr);
        count_value = '0;
        if (op_reg == OP_READ)
        begin
            count_value = READ_W'(row_reg[rch_reg]);
        end
        out_data_next = {{(OUT_DATA_W-READ_W-CHANNELS-1){1'b0}}, count_value, seen_next, qual};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            mask_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_ENABLE:       enable_reg <= cfg_wdata[0];
                REG_CHANNEL_MASK: mask_reg   <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hist0_reg     <= '0;
            hist1_reg     <= '0;
            hist2_reg     <= '0;
            seen_reg      <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (commit)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (commit && tick_on)
            begin
                hist2_reg <= hist1_reg;
                hist1_reg <= hist0_reg;
                hist0_reg <= pins_reg;
                seen_reg  <= seen_next;
            end
            if (mem_we)
            begin
                row_valid_reg[s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(s_axis_tuser);
            pins_reg <= s_axis_tdata[15:0];
            slot_reg <= in_slot;
            rch_reg  <= s_axis_tdata[20:17];
        end
        if (commit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[s1_addr] <= row_wr;
        end
        if (accept)
        begin
            if (!in_ok)
            begin
                row_reg <= '0;
            end
            else if (fwd)
            begin
                row_reg <= row_wr;
            end
            else if (!row_valid_reg[in_addr])
            begin
                row_reg <= '0;
            end
            else
            begin
                row_reg <= mem[in_addr];
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_read_no_pulses: assert property (@(posedge clk) disable iff (!rst_n)
        commit && (op_reg == OP_READ) |=> m_axis_tdata[15:0] == '0)
        else $error("read result carries qualified pulses");

    a_pulse_sets_seen: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[15:0] != '0) |-> m_axis_tdata[16])
        else $error("pulse counted without sticky flag");

    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |=> seen_reg)
        else $error("sticky flag cleared");

    a_row_marked: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> row_valid_reg[$past(s1_addr)])
        else $error("written bank row not marked valid");

    a_disabled_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        commit && !enable_reg |=> $stable(hist0_reg) && $stable(row_valid_reg))
        else $error("disabled tick changed state");

endmodule

// ----- verif/pulse_count_checker.sv -----
`timescale 1ns / 1ps

module pulse_count_checker
    import pic_pkg::*;
#(
    parameter int SLOT_COUNT  = 2,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata,

    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    // [15:0] pin_levels, [16] slot, [20:17] read_channel, [23:21] zero
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // [0] operation
    input  logic                   s_axis_tuser,

    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [15:0] qualified_pulses, [16] pulse_seen, [48:17] count_value, [55:49] zero
    input  logic [OUT_DATA_W-1:0]  m_axis_tdata,

    output int                     fail_count,
    output int                     outstanding
);

    localparam int RES_W = CHANNELS + 1 + READ_W;

    typedef struct packed
    {
        logic [READ_W-1:0] count;
        logic              seen;
        chan_mask_t        qual;
    } pulse_result_t;

    logic                   enabled;
    chan_mask_t             allow_mask;
    chan_mask_t             idle_hist [3];
    logic [COUNT_WIDTH-1:0] bank [SLOT_COUNT*CHANNELS];
    logic                   seen_sticky;
    pulse_result_t          awaited_results [$];

    function automatic pulse_result_t advance_counters(op_t op, chan_mask_t pins, logic slot,
                                                       logic [CH_W-1:0] rch);
        pulse_result_t res;
        chan_mask_t    hits;
        logic [63:0]   wide;
        int            base;
        int            i;
        res  = '0;
        hits = '0;
        wide = '0;
        base = int'(slot) * CHANNELS;
        if (op == OP_READ)
        begin
            if (int'(slot) < SLOT_COUNT)
            begin
                wide      = 64'(bank[base + int'(rch)]);
                res.count = wide[READ_W-1:0];
            end
        end
        else if (enabled)
        begin
            hits = ~pins & idle_hist[0] & idle_hist[1] & idle_hist[2] & allow_mask;
            if (hits != '0)
                seen_sticky = 1'b1;
            if (int'(slot) < SLOT_COUNT)
            begin
                for (i = 0; i < CHANNELS; i++)
                begin
                    if (hits[i])
                        bank[base + i] = bank[base + i] + 1'b1;
                end
            end
            idle_hist[2] = idle_hist[1];
            idle_hist[1] = idle_hist[0];
            idle_hist[0] = pins;
        end
        res.qual = hits;
        res.seen = seen_sticky;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pulse_result_t want;
        pulse_result_t got;
        if (!rst_n)
        begin
            enabled     = 1'b0;
            allow_mask  = '0;
            seen_sticky = 1'b0;
            for (int k = 0; k < 3; k++)
                idle_hist[k] = '0;
            for (int k = 0; k < SLOT_COUNT*CHANNELS; k++)
                bank[k] = '0;
            awaited_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = pulse_result_t'(m_axis_tdata[RES_W-1:0]);
                if (awaited_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: qual %h seen %b count %h",
                                 got.qual, got.seen, got.count);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.qual !== want.qual || got.seen !== want.seen ||
                        got.count !== want.count ||
                        m_axis_tdata[OUT_DATA_W-1:RES_W] !== '0)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp qual %h seen %b count %h pad 0, got qual %h seen %b count %h pad %h",
                                     want.qual, want.seen, want.count,
                                     got.qual, got.seen, got.count,
                                     m_axis_tdata[OUT_DATA_W-1:RES_W]);
                    end
                end
            end
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_ENABLE:       enabled    = cfg_wdata[0];
                    REG_CHANNEL_MASK: allow_mask = cfg_wdata[CHANNELS-1:0];
                    default:          ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_results.push_back(advance_counters(op_t'(s_axis_tuser),
                                                           s_axis_tdata[CHANNELS-1:0],
                                                           s_axis_tdata[CHANNELS],
                                                           s_axis_tdata[CHANNELS+CH_W:CHANNELS+1]));
            outstanding <= awaited_results.size();
        end
    end

endmodule

// ----- verif/tb_pulse_input_edge_counter.sv -----
`timescale 1ns / 1ps

module tb_pulse_input_edge_counter;

    import pic_pkg::*;

    localparam int SLOT_COUNT     = 2;
    localparam int COUNT_WIDTH    = 32;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_GAP        = 60;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic                  cfg_index     = REG_ENABLE;
    logic [CFG_W-1:0]      cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = OP_TICK;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int   fail_count;
    int   outstanding;
    int   idle_pct    = 0;
    int   stall_pct   = 0;
    int   hold_left   = 0;
    int   quiet_count = 0;
    logic hold_req    = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    pulse_input_edge_counter #(
        .SLOT_COUNT  (SLOT_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pulse_count_checker #(
        .SLOT_COUNT  (SLOT_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // hold off for a fixed stretch on request, otherwise stall at random
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= WATCHDOG_LIMIT)
        begin
            $display("tb_pulse_input_edge_counter: done, errors");
            $finish;
        end
    end

    task automatic send_item(op_t op, chan_mask_t pins, logic slot, logic [CH_W-1:0] rch);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, rch, slot, pins};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // drop valid and wait for every outstanding result, then let the pipeline settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(logic en, chan_mask_t mask);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ENABLE;
        cfg_wdata <= CFG_W'(en);
        @(posedge clk);
        cfg_index <= REG_CHANNEL_MASK;
        cfg_wdata <= mask;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_item();
        int         pick;
        chan_mask_t pins;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            send_item(OP_READ, chan_mask_t'($urandom), 1'($urandom), CH_W'($urandom));
        else
        begin
            // mostly inactive pins so that leading edges qualify often
            if (pick < 30)
                pins = chan_mask_t'($urandom);
            else
                pins = ~chan_mask_t'($urandom & $urandom);
            send_item(OP_TICK, pins, 1'($urandom), CH_W'($urandom));
        end
    endtask

    initial
    begin
        int         n_items;
        logic       en;
        chan_mask_t mask;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled tick and read straight after reset
        send_item(OP_TICK, 16'h0000, 1'b0, 4'h0);
        send_item(OP_READ, 16'hFFFF, 1'b1, 4'hF);
        drain();
        write_regs(1'b1, 16'hFFFF);

        // history still zero: the first tick may not qualify; later ticks qualify after three inactive ones
        send_item(OP_TICK, 16'h0000, 1'b0, 4'h0);
        repeat (3) send_item(OP_TICK, 16'hFFFF, 1'b0, 4'h5);
        send_item(OP_TICK, 16'h0000, 1'b0, 4'hA);
        repeat (3) send_item(OP_TICK, 16'hFFFF, 1'b1, 4'hF);
        send_item(OP_TICK, 16'h0000, 1'b1, 4'h0);
        send_item(OP_READ, 16'h5555, 1'b0, 4'h0);
        send_item(OP_READ, 16'hAAAA, 1'b0, 4'hF);
        send_item(OP_READ, 16'h0000, 1'b1, 4'h0);
        send_item(OP_READ, 16'hFFFF, 1'b1, 4'hF);
        send_item(OP_TICK, 16'hAAAA, 1'b0, 4'h3);
        send_item(OP_TICK, 16'hFFFF, 1'b0, 4'hC);
        send_item(OP_TICK, 16'hFFFF, 1'b1, 4'h7);
        drain();

        // disabled tick must leave history and counters alone
        write_regs(1'b0, 16'hFFFF);
        send_item(OP_TICK, 16'h0000, 1'b0, 4'h0);
        send_item(OP_READ, 16'h0000, 1'b0, 4'h1);
        drain();
        write_regs(1'b1, 16'hFFFF);
        send_item(OP_TICK, 16'h5555, 1'b0, 4'h8);

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  en = 1'b1; mask = 16'hFFFF;         n_items = 400; end
                1:       begin idle_pct = 82; stall_pct = 0;  en = 1'b1; mask = chan_mask_t'($urandom); n_items = 300; end
                2:       begin idle_pct = 0;  stall_pct = 82; en = 1'b0; mask = 16'hFFFF;         n_items = 60;  end
                3:       begin idle_pct = 0;  stall_pct = 82; en = 1'b1; mask = 16'h0000;         n_items = 60;  end
                4:       begin idle_pct = 29; stall_pct = 29; en = 1'b1; mask = chan_mask_t'($urandom); n_items = 500; end
                default: begin idle_pct = 0;  stall_pct = 0;  en = 1'b1; mask = 16'hFFFF;         n_items = 200; end
            endcase
            drain();
            write_regs(en, mask);
            for (int k = 0; k < n_items; k++)
            begin
                if (ph == 0 && k == 200)
                    hold_req = 1'b1;
                if (ph == 1 && k == 150)
                    drain();
                random_item();
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb_pulse_input_edge_counter: done, clean");
        else
            $display("tb_pulse_input_edge_counter: done, errors");
        $finish;
    end

endmodule
